// ===== hdl/pirc_pkg.sv =====
// ----------------------------------------------------------------------------
// pirc_pkg: shared types and constants for the pair instability correction
// Holds the result type codes, the fit branch codes, the stage control
// struct and the fit coefficients at 2^-24 with their rounding function.
// ----------------------------------------------------------------------------
package pirc_pkg;

  typedef enum logic [1:0] {
    SN_CC  = 2'd0,
    SN_PPI = 2'd1,
    SN_PI  = 2'd2
  } sn_type_e;

  // Which expression supplies the correction factor.
  typedef enum logic [2:0] {
    BR_ONE    = 3'd0,
    BR_ZERO   = 3'd1,
    BR_L_LOW  = 3'd2,
    BR_L_MID  = 3'd3,
    BR_L_HIGH = 3'd4,
    BR_H_LOW  = 3'd5,
    BR_H_MID  = 3'd6,
    BR_H_HIGH = 3'd7
  } branch_e;

  typedef struct packed {
    logic     valid;
    sn_type_e sn_type;
    branch_e  branch;
  } stage_ctl_t;

  // Decimal coefficients rounded to nearest at 2^-24.
  localparam longint unsigned K24_0_67     = 64'd11240735;
  localparam longint unsigned K24_0_1      = 64'd1677722;
  localparam longint unsigned K24_0_5226   = 64'd8767773;
  localparam longint unsigned K24_0_52974  = 64'd8887562;
  localparam longint unsigned K24_0_82916  = 64'd13910996;
  localparam longint unsigned K24_0_103645 = 64'd1738875;
  localparam longint unsigned K24_6_63328  = 64'd111287971;
  localparam longint unsigned K24_0_1381   = 64'd2316934;
  localparam longint unsigned K24_0_1309   = 64'd2196138;

  // Re-rounds a 2^-24 coefficient to nearest at 2^-fb.
  function automatic longint unsigned qc(input longint unsigned k24, input int unsigned fb);
    return ((k24 << fb) + (64'd1 << 23)) >> 24;
  endfunction

endpackage

// ===== hdl/pirc_div.sv =====
// ----------------------------------------------------------------------------
// pirc_div: pipelined helium fraction divider
// Restoring division, one quotient bit per stage, saturating to one when the
// total mass is zero or not above the helium mass.
// ----------------------------------------------------------------------------
module pirc_div #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned INT_BITS  = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [INT_BITS+FRAC_BITS-1:0] he_i,
  input  logic [INT_BITS+FRAC_BITS-1:0] tot_i,
  input  logic [INT_BITS+FRAC_BITS-1:0] rem_i,
  output logic                          valid_o,
  output logic [FRAC_BITS:0]            frac_o,
  output logic [INT_BITS+FRAC_BITS-1:0] he_o,
  output logic [INT_BITS+FRAC_BITS-1:0] rem_o
);

  localparam int unsigned MB = INT_BITS + FRAC_BITS;
  localparam int unsigned FB = FRAC_BITS;

  logic [MB-1:0] r_q   [FB+1];
  logic [MB-1:0] tot_q [FB+1];
  logic [MB-1:0] he_q  [FB+1];
  logic [MB-1:0] rem_q [FB+1];
  logic [FB-1:0] quo_q [FB+1];
  logic          sat_q [FB+1];
  logic          vld_q [FB+1];

  logic sat_d;
  assign sat_d = (tot_i == '0) || (he_i >= tot_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= sat_d ? '0 : he_i;
      tot_q[0] <= tot_i;
      he_q[0]  <= he_i;
      rem_q[0] <= rem_i;
      quo_q[0] <= '0;
      sat_q[0] <= sat_d;
    end
  end

  for (genvar i = 0; i < FB; i++) begin : g_step
    logic [MB:0]   r2;
    logic [MB:0]   diff;
    logic          ge;
    assign r2   = {r_q[i], 1'b0};
    assign diff = r2 - {1'b0, tot_q[i]};
    assign ge   = (r2 >= {1'b0, tot_q[i]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[i+1]   <= ge ? diff[MB-1:0] : r2[MB-1:0];
        tot_q[i+1] <= tot_q[i];
        he_q[i+1]  <= he_q[i];
        rem_q[i+1] <= rem_q[i];
        quo_q[i+1] <= {quo_q[i][FB-2:0], ge};
        sat_q[i+1] <= sat_q[i];
      end
    end
  end

  assign valid_o = vld_q[FB];
  assign frac_o  = sat_q[FB] ? (FB+1)'(1) << FB : {1'b0, quo_q[FB]};
  assign he_o    = he_q[FB];
  assign rem_o   = rem_q[FB];

endmodule

// ===== hdl/pirc_factor.sv =====
// ----------------------------------------------------------------------------
// pirc_factor: correction factor pipeline
// Four stages: coefficient products, branch products, reciprocal divide by
// five, then branch selection with clamping to the Q2 range.
// ----------------------------------------------------------------------------
module pirc_factor #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned INT_BITS  = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [FRAC_BITS:0]            frac_i,
  input  logic [INT_BITS+FRAC_BITS-1:0] he_i,
  input  logic [INT_BITS+FRAC_BITS-1:0] rem_i,
  output logic                          valid_o,
  output pirc_pkg::sn_type_e            sn_type_o,
  output logic [FRAC_BITS+1:0]          factor_o,
  output logic [INT_BITS+FRAC_BITS-1:0] rem_o
);

  localparam int unsigned FB = FRAC_BITS;
  localparam int unsigned MB = INT_BITS + FRAC_BITS;
  localparam int unsigned HW = FB + 6;
  localparam int unsigned SW = FB + 12;
  localparam int unsigned XW = HW + 1;
  localparam int unsigned RS = XW + 1;
  localparam longint unsigned RECIP5 = (64'd1 << RS) / 5;

  localparam longint unsigned C67  = pirc_pkg::qc(pirc_pkg::K24_0_67, FB);
  localparam longint unsigned C01  = pirc_pkg::qc(pirc_pkg::K24_0_1, FB);
  localparam longint unsigned C522 = pirc_pkg::qc(pirc_pkg::K24_0_5226, FB);
  localparam longint unsigned C529 = pirc_pkg::qc(pirc_pkg::K24_0_52974, FB);
  localparam longint unsigned C829 = pirc_pkg::qc(pirc_pkg::K24_0_82916, FB);
  localparam longint unsigned C103 = pirc_pkg::qc(pirc_pkg::K24_0_103645, FB);
  localparam longint unsigned C663 = pirc_pkg::qc(pirc_pkg::K24_6_63328, FB);
  localparam longint unsigned C138 = pirc_pkg::qc(pirc_pkg::K24_0_1381, FB);
  localparam longint unsigned C130 = pirc_pkg::qc(pirc_pkg::K24_0_1309, FB);

  localparam logic [MB-1:0] H32  = MB'(32) << FB;
  localparam logic [MB-1:0] H37  = MB'(37) << FB;
  localparam logic [MB-1:0] H56  = MB'(56) << FB;
  localparam logic [MB-1:0] H60  = MB'(60) << FB;
  localparam logic [MB-1:0] H64  = MB'(64) << FB;
  localparam logic [MB-1:0] H135 = MB'(135) << FB;
  localparam logic [HW-1:0] H32S = HW'(32) << FB;
  localparam logic [HW-1:0] H56S = HW'(56) << FB;
  localparam logic signed [SW-1:0] ONE  = SW'(1) << FB;
  localparam logic signed [SW-1:0] FMAX = (SW'(4) << FB) - SW'(1);

  // ---- stage A: coefficient products and region decode -------------------
  logic [2*FB+1:0]         p67, p522, p138;
  logic [HW+FB-1:0]        p103;
  logic [HW-1:0]           h6;
  logic                    is_ppi, is_pi, low_f;
  pirc_pkg::stage_ctl_t    ctl_a_d, ctl_a_q;
  logic [FB:0]             k_a_d, k_a_q;
  logic signed [SW-1:0]    m_a_d, m_a_q, g_a_d, g_a_q, c6_a_d, c6_a_q;
  logic [HW-1:0]           hd_a_q, h64_a_q, h56_a_q;
  logic [MB-1:0]           rem_a_q;

  always_comb begin
    h6     = he_i[HW-1:0];
    p67    = (2*FB+2)'(frac_i) * (2*FB+2)'(C67);
    p522   = (2*FB+2)'(frac_i) * (2*FB+2)'(C522);
    p138   = (2*FB+2)'(frac_i) * (2*FB+2)'(C138);
    p103   = (HW+FB)'(h6) * (HW+FB)'(C103);
    k_a_d  = (FB+1)'(p67 >> FB) + (FB+1)'(C01);
    m_a_d  = SW'(C529) - SW'(p522 >> FB);
    g_a_d  = SW'(p138 >> FB) - SW'(C130);
    c6_a_d = SW'(C663) - SW'(p103 >> FB);
    is_ppi = (he_i > H32) && (he_i < H64);
    is_pi  = (he_i >= H64) && (he_i < H135);
    low_f  = (SW'(frac_i) < SW'(C01 * 9));
    ctl_a_d.valid = valid_i;
    if (is_ppi) begin
      ctl_a_d.sn_type = pirc_pkg::SN_PPI;
      if (low_f) begin
        if (he_i <= H37) begin
          ctl_a_d.branch = pirc_pkg::BR_L_LOW;
        end else if (he_i <= H60) begin
          ctl_a_d.branch = pirc_pkg::BR_L_MID;
        end else begin
          ctl_a_d.branch = pirc_pkg::BR_L_HIGH;
        end
      end else begin
        if (he_i <= H37) begin
          ctl_a_d.branch = pirc_pkg::BR_H_LOW;
        end else if (he_i <= H56) begin
          ctl_a_d.branch = pirc_pkg::BR_H_MID;
        end else begin
          ctl_a_d.branch = pirc_pkg::BR_H_HIGH;
        end
      end
    end else if (is_pi) begin
      ctl_a_d.sn_type = pirc_pkg::SN_PI;
      ctl_a_d.branch  = pirc_pkg::BR_ZERO;
    end else begin
      ctl_a_d.sn_type = pirc_pkg::SN_CC;
      ctl_a_d.branch  = pirc_pkg::BR_ONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '{valid: 1'b0, sn_type: pirc_pkg::SN_CC, branch: pirc_pkg::BR_ONE};
    end else if (en_i) begin
      ctl_a_q <= ctl_a_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      k_a_q   <= k_a_d;
      m_a_q   <= m_a_d;
      g_a_q   <= g_a_d;
      c6_a_q  <= c6_a_d;
      hd_a_q  <= h6 - H32S;
      h64_a_q <= HW'(0) - h6;
      h56_a_q <= H56S - h6;
      rem_a_q <= rem_i;
    end
  end

  // ---- stage B: branch products --------------------------------------------
  logic [FB:0]             omk;
  logic [FB+1+HW-1:0]      px5, py4;
  logic [SW-1:0]           m_mag, g_mag;
  logic [SW+HW-1:0]        pm, pg;
  logic signed [SW-1:0]    a_b_d, bb_b_d;
  pirc_pkg::stage_ctl_t    ctl_b_q;
  logic [XW-1:0]           x5_b_q;
  logic signed [SW-1:0]    y4_b_q, a_b_q, v_b_q, bb_b_q, c6_b_q;
  logic [FB:0]             k_b_q;
  logic [MB-1:0]           rem_b_q;

  always_comb begin
    omk   = (FB+1)'(ONE) - k_a_q;
    px5   = (FB+1+HW)'(omk) * (FB+1+HW)'(hd_a_q);
    py4   = (FB+1+HW)'(k_a_q) * (FB+1+HW)'(h64_a_q);
    m_mag = m_a_q[SW-1] ? SW'(-m_a_q) : SW'(m_a_q);
    g_mag = g_a_q[SW-1] ? SW'(-g_a_q) : SW'(g_a_q);
    pm    = (SW+HW)'(m_mag) * (SW+HW)'(hd_a_q);
    pg    = (SW+HW)'(g_mag) * (SW+HW)'(h56_a_q);
    a_b_d  = m_a_q[SW-1] ? -SW'(pm >> FB) : SW'(pm >> FB);
    bb_b_d = g_a_q[SW-1] ? -SW'(pg >> FB) : SW'(pg >> FB);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_b_q <= '{valid: 1'b0, sn_type: pirc_pkg::SN_CC, branch: pirc_pkg::BR_ONE};
    end else if (en_i) begin
      ctl_b_q <= ctl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x5_b_q  <= XW'(px5 >> FB);
      y4_b_q  <= SW'(py4 >> (FB + 2));
      a_b_q   <= a_b_d;
      bb_b_q  <= bb_b_d;
      v_b_q   <= ONE - (m_a_q <<< 2) - m_a_q;
      c6_b_q  <= c6_a_q;
      k_b_q   <= k_a_q;
      rem_b_q <= rem_a_q;
    end
  end

  // ---- stage C: divide by five through a reciprocal ------------------------
  logic [XW+RS-1:0]        pq;
  pirc_pkg::stage_ctl_t    ctl_c_q;
  logic [XW-1:0]           x5_c_q, q0_c_q;
  logic signed [SW-1:0]    y4_c_q, la_c_q, lb_c_q, v_c_q, c6_c_q;
  logic                    vlt_c_q;
  logic [FB:0]             k_c_q;
  logic [MB-1:0]           rem_c_q;

  assign pq = (XW+RS)'(x5_b_q) * (XW+RS)'(RECIP5);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_c_q <= '{valid: 1'b0, sn_type: pirc_pkg::SN_CC, branch: pirc_pkg::BR_ONE};
    end else if (en_i) begin
      ctl_c_q <= ctl_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x5_c_q  <= x5_b_q;
      q0_c_q  <= XW'(pq >> RS);
      y4_c_q  <= y4_b_q;
      la_c_q  <= ONE - a_b_q;
      lb_c_q  <= SW'(C829) + bb_b_q;
      v_c_q   <= v_b_q;
      vlt_c_q <= (v_b_q < SW'(C829));
      c6_c_q  <= c6_b_q;
      k_c_q   <= k_b_q;
      rem_c_q <= rem_b_q;
    end
  end

  // ---- stage D: correction, selection and clamp ----------------------------
  logic [XW-1:0]           rem5, quo5;
  logic signed [SW-1:0]    sel, fac_d;
  pirc_pkg::stage_ctl_t    ctl_d_q;
  logic [FB+1:0]           fac_q;
  logic [MB-1:0]           rem_d_q;

  always_comb begin
    rem5 = x5_c_q - ((q0_c_q << 2) + q0_c_q);
    quo5 = q0_c_q + XW'(rem5 >= XW'(5));
    case (ctl_c_q.branch)
      pirc_pkg::BR_ONE:    sel = ONE;
      pirc_pkg::BR_ZERO:   sel = '0;
      pirc_pkg::BR_L_LOW:  sel = ONE - SW'(quo5);
      pirc_pkg::BR_L_MID:  sel = SW'(k_c_q);
      pirc_pkg::BR_L_HIGH: sel = y4_c_q;
      pirc_pkg::BR_H_LOW:  sel = la_c_q;
      pirc_pkg::BR_H_MID:  sel = vlt_c_q ? v_c_q : lb_c_q;
      pirc_pkg::BR_H_HIGH: sel = c6_c_q;
      default:             sel = ONE;
    endcase
    if (sel < 0) begin
      fac_d = '0;
    end else if (sel > FMAX) begin
      fac_d = FMAX;
    end else begin
      fac_d = sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_d_q <= '{valid: 1'b0, sn_type: pirc_pkg::SN_CC, branch: pirc_pkg::BR_ONE};
    end else if (en_i) begin
      ctl_d_q <= ctl_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fac_q   <= fac_d[FB+1:0];
      rem_d_q <= rem_c_q;
    end
  end

  assign valid_o   = ctl_d_q.valid;
  assign sn_type_o = ctl_d_q.sn_type;
  assign factor_o  = fac_q;
  assign rem_o     = rem_d_q;

endmodule

// ===== hdl/pirc_mul.sv =====
// ----------------------------------------------------------------------------
// pirc_mul: remnant scaling and output register
// Multiplies the remnant by the factor, saturates, applies the minimum
// remnant rule and holds the result for the output channel.
// ----------------------------------------------------------------------------
module pirc_mul #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned INT_BITS  = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  pirc_pkg::sn_type_e            sn_type_i,
  input  logic [FRAC_BITS+1:0]          factor_i,
  input  logic [INT_BITS+FRAC_BITS-1:0] rem_i,
  input  logic [INT_BITS+FRAC_BITS-1:0] min_rem_i,
  output logic                          valid_o,
  output pirc_pkg::sn_type_e            sn_type_o,
  output logic [INT_BITS+FRAC_BITS-1:0] mass_o
);

  localparam int unsigned FB = FRAC_BITS;
  localparam int unsigned MB = INT_BITS + FRAC_BITS;
  localparam logic [FB+1:0] FONE = (FB+2)'(1) << FB;

  logic [MB+FB+1:0]   prod;
  logic               vld_e_q, vld_f_q;
  pirc_pkg::sn_type_e typ_e_q, typ_f_q, typ_d;
  logic [MB+1:0]      p_e_q;
  logic               not_one_e_q;
  logic [MB-1:0]      sat, mass_d, mass_q;

  assign prod = (MB+FB+2)'(rem_i) * (MB+FB+2)'(factor_i);

  always_comb begin
    sat = (p_e_q > (MB+2)'({MB{1'b1}})) ? {MB{1'b1}} : p_e_q[MB-1:0];
    if (not_one_e_q && (sat < min_rem_i)) begin
      mass_d = '0;
      typ_d  = pirc_pkg::SN_PI;
    end else begin
      mass_d = sat;
      typ_d  = typ_e_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_e_q <= 1'b0;
      vld_f_q <= 1'b0;
    end else if (en_i) begin
      vld_e_q <= valid_i;
      vld_f_q <= vld_e_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_e_q       <= (MB+2)'(prod >> FB);
      not_one_e_q <= (factor_i != FONE);
      typ_e_q     <= sn_type_i;
      mass_q      <= mass_d;
      typ_f_q     <= typ_d;
    end
  end

  assign valid_o   = vld_f_q;
  assign sn_type_o = typ_f_q;
  assign mass_o    = mass_q;

endmodule

// ===== hdl/pair_instability_remnant_correction.sv =====
// ----------------------------------------------------------------------------
// pair_instability_remnant_correction: remnant mass correction pipeline
// Requests pass in order through the fraction divider, the factor path and
// the scaling stage. Throughput is one request per cycle while the output
// is not stalled and no threshold write is taken; the fraction divider's
// one quotient bit per stage sets the depth. Reset clears all valid bits
// and loads min_remnant with 4.5 solar masses.
// ----------------------------------------------------------------------------
module pair_instability_remnant_correction #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned INT_BITS  = 10
) (
  input  logic clk_i,
  input  logic rst_ni,

  // Input requests.
  input  logic                                            s_axis_tvalid,
  output logic                                            s_axis_tready,
  // Fields from bit 0 up: helium_mass, total_mass, remnant_mass, zero pad.
  input  logic [((3*(INT_BITS+FRAC_BITS)+7)/8)*8-1:0]     s_axis_tdata,

  // Result requests.
  output logic                                            m_axis_tvalid,
  input  logic                                            m_axis_tready,
  // Fields from bit 0 up: scaled remnant mass, zero pad.
  output logic [((INT_BITS+FRAC_BITS+7)/8)*8-1:0]         m_axis_tdata,
  // Fields from bit 0 up: sn_type.
  output logic [1:0]                                      m_axis_tuser,

  // Configuration write of min_remnant.
  input  logic                                            cfg_valid_i,
  output logic                                            cfg_ready_o,
  input  logic [INT_BITS+FRAC_BITS-1:0]                   cfg_data_i
);

  localparam int unsigned MB = INT_BITS + FRAC_BITS;
  localparam int unsigned OW = ((MB + 7) / 8) * 8;
  localparam int unsigned CW = $clog2(FRAC_BITS + 8);
  localparam logic [MB-1:0] MIN_RESET = MB'((64'd9 << FRAC_BITS) >> 1);

  // The threshold register is written only while the pipeline is empty, so
  // every request sees the threshold that was set when it was accepted. A
  // count of requests in flight tells when the pipeline is empty.
  logic [MB-1:0] min_rem_q;
  logic [CW-1:0] inflight_d, inflight_q;
  logic          in_req, out_req;

  assign cfg_ready_o = (inflight_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_rem_q <= MIN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      min_rem_q <= cfg_data_i;
    end
  end

  // The whole pipeline moves together. It advances whenever the output
  // register is empty or its request is taken this cycle, so a stall freezes
  // every stage in place and nothing is dropped or repeated. A threshold
  // write that is taken holds off the input for that cycle.
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !(cfg_valid_i && cfg_ready_o);

  assign in_req     = s_axis_tvalid && s_axis_tready;
  assign out_req    = m_axis_tvalid && m_axis_tready;
  assign inflight_d = inflight_q + CW'(in_req) - CW'(out_req);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // Helium fraction: helium over total mass, as a Q1 fraction with one
  // standing for saturation.
  logic              div_valid;
  logic [FRAC_BITS:0] div_frac;
  logic [MB-1:0]     div_he, div_rem;

  pirc_div #(
    .FRAC_BITS (FRAC_BITS),
    .INT_BITS  (INT_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_req),
    .he_i    (s_axis_tdata[MB-1:0]),
    .tot_i   (s_axis_tdata[2*MB-1:MB]),
    .rem_i   (s_axis_tdata[3*MB-1:2*MB]),
    .valid_o (div_valid),
    .frac_o  (div_frac),
    .he_o    (div_he),
    .rem_o   (div_rem)
  );

  // Correction factor from the fitted branches, clamped to [0, 4).
  logic               fac_valid;
  pirc_pkg::sn_type_e fac_type;
  logic [FRAC_BITS+1:0] fac_value;
  logic [MB-1:0]      fac_rem;

  pirc_factor #(
    .FRAC_BITS (FRAC_BITS),
    .INT_BITS  (INT_BITS)
  ) u_factor (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (div_valid),
    .frac_i    (div_frac),
    .he_i      (div_he),
    .rem_i     (div_rem),
    .valid_o   (fac_valid),
    .sn_type_o (fac_type),
    .factor_o  (fac_value),
    .rem_o     (fac_rem)
  );

  // Scaling, saturation and the minimum remnant rule; the last register of
  // this unit is the output register.
  pirc_pkg::sn_type_e out_type;
  logic [MB-1:0]      out_mass;

  pirc_mul #(
    .FRAC_BITS (FRAC_BITS),
    .INT_BITS  (INT_BITS)
  ) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (fac_valid),
    .sn_type_i (fac_type),
    .factor_i  (fac_value),
    .rem_i     (fac_rem),
    .min_rem_i (min_rem_q),
    .valid_o   (m_axis_tvalid),
    .sn_type_o (out_type),
    .mass_o    (out_mass)
  );

  assign m_axis_tdata = OW'(out_mass);
  assign m_axis_tuser = out_type;

endmodule

// ===== tb/pair_instability_remnant_correction_test.sv =====
// ----------------------------------------------------------------------------
// pair_instability_remnant_correction_test: stream test of the remnant fix
// Drives star records through the input stream, predicts each corrected
// mass and type in the bench, and checks every result in order while both
// sides idle at random and min_remnant is stepped through several values.
// ----------------------------------------------------------------------------
module pair_instability_remnant_correction_test;

  localparam int unsigned FB      = 16;
  localparam int unsigned IB      = 10;
  localparam int unsigned MW      = IB + FB;
  localparam int unsigned IN_W    = ((3 * MW + 7) / 8) * 8;
  localparam int unsigned OUT_W   = ((MW + 7) / 8) * 8;
  localparam int unsigned LATENCY = FB + 7;
  localparam int unsigned WD_MAX  = 20000;
  localparam logic [MW-1:0] MASS_MAX = {MW{1'b1}};

  typedef struct packed {
    logic [MW-1:0]      mass;
    pirc_pkg::sn_type_e kind;
  } remnant_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [1:0]       m_axis_tuser;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [MW-1:0]    cfg_data_i = '0;

  // Bench copy of the threshold register and the queue of predicted remnants.
  logic [MW-1:0] floor_mass;
  remnant_t      pending_remnants[$];
  int            mismatches = 0;
  int            watchdog = 0;
  bit            sink_idles = 1'b1;
  bit            sink_hold = 1'b0;

  always #1 clk_i = ~clk_i;

  pair_instability_remnant_correction #(.FRAC_BITS(FB), .INT_BITS(IB)) u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  // Coefficient at 2^-24 rounded to nearest at 2^-FB.
  function automatic longint coef(input longint k24);
    return ((k24 <<< FB) + (64'sd1 <<< 23)) >>> 24;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return longint'((64'(a) * 64'(b)) >> FB);
  endfunction

  // Signed coefficient times a non-negative value, magnitude truncated.
  function automatic longint qmul_signed(input longint a, input longint b);
    return (a < 0) ? -qmul(-a, b) : qmul(a, b);
  endfunction

  // Predicts the corrected remnant of one star record.
  function automatic remnant_t correct_remnant(input logic [MW-1:0] he,
                                               input logic [MW-1:0] tot,
                                               input logic [MW-1:0] rem);
    longint   h, one, frac, fac, k, m, v, g;
    longint unsigned prod;
    remnant_t res;
    h   = longint'(he);
    one = 64'sd1 <<< FB;
    if (tot == 0 || he >= tot) frac = one;
    else frac = longint'((64'(he) << FB) / 64'(tot));
    if (h > (64'sd32 <<< FB) && h < (64'sd64 <<< FB)) begin
      res.kind = pirc_pkg::SN_PPI;
      if (frac < coef(pirc_pkg::K24_0_1) * 9) begin
        k = qmul(coef(pirc_pkg::K24_0_67), frac) + coef(pirc_pkg::K24_0_1);
        if (h <= (64'sd37 <<< FB)) fac = one - qmul(one - k, h - (64'sd32 <<< FB)) / 5;
        else if (h <= (64'sd60 <<< FB)) fac = k;
        else fac = qmul(k, (64'sd64 <<< FB) - h) / 4;
      end else begin
        m = coef(pirc_pkg::K24_0_52974) - qmul(coef(pirc_pkg::K24_0_5226), frac);
        if (h <= (64'sd37 <<< FB)) begin
          fac = one - qmul_signed(m, h - (64'sd32 <<< FB));
        end else if (h <= (64'sd56 <<< FB)) begin
          v = one - 5 * m;
          if (v < coef(pirc_pkg::K24_0_82916)) begin
            fac = v;
          end else begin
            g = qmul(coef(pirc_pkg::K24_0_1381), frac) - coef(pirc_pkg::K24_0_1309);
            fac = coef(pirc_pkg::K24_0_82916) + qmul_signed(g, (64'sd56 <<< FB) - h);
          end
        end else begin
          fac = coef(pirc_pkg::K24_6_63328) - qmul(coef(pirc_pkg::K24_0_103645), h);
        end
      end
    end else if (h >= (64'sd64 <<< FB) && h < (64'sd135 <<< FB)) begin
      res.kind = pirc_pkg::SN_PI;
      fac = 0;
    end else begin
      res.kind = pirc_pkg::SN_CC;
      fac = one;
    end
    if (fac < 0) fac = 0;
    if (fac > 4 * one - 1) fac = 4 * one - 1;
    prod = 64'(rem) * (64'(fac) >> FB) + ((64'(rem) * (64'(fac) & (one - 1))) >> FB);
    if (prod > 64'(MASS_MAX)) prod = 64'(MASS_MAX);
    if (fac != one && prod < 64'(floor_mass)) begin
      prod = 0;
      res.kind = pirc_pkg::SN_PI;
    end
    res.mass = prod[MW-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch in %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  // Offers one star record, predicting its remnant when the request is taken.
  task automatic send_star(input logic [MW-1:0] he, input logic [MW-1:0] tot,
                           input logic [MW-1:0] rem, input bit gaps);
    int gap;
    if (gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({rem, tot, he});
    do @(posedge clk_i); while (!s_axis_tready);
    pending_remnants.push_back(correct_remnant(he, tot, rem));
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
  endtask

  // Waits until every prediction has been met, then lets the pipe drain.
  task automatic drain();
    stop_sending();
    while (pending_remnants.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_floor(input logic [MW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    floor_mass = value;
  endtask

  function automatic logic [MW-1:0] solar(input int whole);
    return MW'(whole) << FB;
  endfunction

  // A helium mass biased toward the fit region, with some full-range values.
  function automatic logic [MW-1:0] rand_helium();
    case ($urandom_range(0, 5))
      0: return MW'($urandom);
      1: return solar($urandom_range(60, 140)) + MW'($urandom_range(0, 65535));
      default: return solar(32) + MW'($urandom_range(0, 32 * 65536));
    endcase
  endfunction

  function automatic logic [MW-1:0] rand_total(input logic [MW-1:0] he);
    case ($urandom_range(0, 5))
      0: return MW'($urandom);
      1: return he;
      2: return '0;
      default: return he + MW'($urandom_range(0, he / 4 + 1));
    endcase
  endfunction

  // Field extremes, each fit branch and the named corner cases.
  task automatic test_directed();
    send_star('0, '0, '0, 0);
    send_star(MASS_MAX, MASS_MAX, MASS_MAX, 0);
    send_star(solar(10), '0, solar(20), 0);
    send_star(solar(40), solar(20), solar(30), 0);
    send_star(solar(135), solar(140), MASS_MAX, 0);
    send_star(solar(134), solar(140), solar(50), 0);
    send_star(solar(64), solar(70), solar(50), 0);
    send_star(solar(32), solar(100), solar(50), 0);
    send_star(solar(33), solar(100), solar(50), 0);
    send_star(solar(37), solar(100), solar(50), 0);
    send_star(solar(50), solar(100), solar(50), 0);
    send_star(solar(62), solar(100), solar(50), 0);
    send_star(solar(33), solar(34), MASS_MAX, 0);
    send_star(solar(37), solar(38), solar(50), 0);
    send_star(solar(45), solar(46), solar(50), 0);
    send_star(solar(56), solar(57), solar(50), 0);
    send_star(solar(60), solar(61), solar(50), 0);
    send_star(solar(63), solar(63), solar(50), 0);
    send_star(solar(36), solar(40), solar(3), 0);
    send_star(solar(40), solar(40) + 1, MASS_MAX, 0);
    send_star(MW'(26'h2aaaaaa), MW'(26'h1555555), MW'(26'h2aaaaaa), 0);
    send_star(MW'(26'h1555555), MW'(26'h2aaaaaa), MW'(26'h1555555), 0);
    drain();
  endtask

  task automatic test_random(input int count, input bit gaps);
    logic [MW-1:0] he;
    repeat (count) begin
      he = rand_helium();
      send_star(he, rand_total(he), MW'($urandom_range(0, 3) == 0 ? $urandom
                                        : $urandom_range(0, 80 * 65536)), gaps);
    end
  endtask

  // Holds the sink off long enough that the pipe fills and backs up.
  task automatic test_backpressure();
    sink_hold = 1'b1;
    test_random(60, 0);
    sink_hold = 1'b0;
    drain();
  endtask

  task automatic test_floor_settings();
    write_floor('0);
    test_random(120, 1);
    drain();
    write_floor(MASS_MAX);
    test_random(60, 1);
    drain();
    write_floor(solar(20));
    test_random(120, 1);
    drain();
    write_floor(MW'($urandom));
    test_random(60, 1);
    drain();
    write_floor(MW'(294912));
  endtask

  // Sink: random stall bursts, one long hold when asked, none at the end.
  initial begin
    int stall;
    forever begin
      @(posedge clk_i);
      if (sink_hold) begin
        m_axis_tready <= 1'b0;
        stall = 200;
        while (stall > 0) begin
          @(posedge clk_i);
          stall--;
        end
        sink_hold = 1'b0;
      end else if (sink_idles && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Checks each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    remnant_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_remnants.size() == 0) begin
        report_mismatch("result with no star record pending", m_axis_tdata[MW-1:0], 0);
      end else begin
        want = pending_remnants.pop_front();
        if (m_axis_tdata[MW-1:0] !== want.mass)
          report_mismatch("remnant mass", m_axis_tdata[MW-1:0], want.mass);
        if (m_axis_tuser !== want.kind)
          report_mismatch("sn_type", m_axis_tuser, want.kind);
      end
    end
  end

  // Watchdog on cycles in which no request of any kind is taken.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      watchdog <= 0;
    end else if (watchdog >= WD_MAX) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      watchdog <= watchdog + 1;
    end
  end

  initial begin
    floor_mass = MW'(294912);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_floor_settings();
    test_backpressure();
    test_random(150, 1);
    drain();
    // Last stretch runs at full rate on both sides.
    sink_idles = 1'b0;
    test_random(80, 0);
    drain();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== pair_instability_remnant_correction.f =====
hdl/pirc_pkg.sv
hdl/pirc_div.sv
hdl/pirc_factor.sv
hdl/pirc_mul.sv
hdl/pair_instability_remnant_correction.sv
tb/pair_instability_remnant_correction_test.sv
